>>> src/pidpd_pkg.sv
package pidpd_pkg;

  localparam int ERR_W  = 17;
  localparam int SUM_W  = 24;
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 8;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int DATA_W = 16;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [IDX_W-1:0] REG_OLIM   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ILIM   = 3'd5;

  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  typedef struct packed {
    logic signed [ERR_W-1:0] err_now;
    logic signed [ERR_W-1:0] err_prev;
    logic signed [SUM_W-1:0] integral_sum;
    logic signed [SUM_W-1:0] output_sum;
  } pidpd_state_t;

  typedef struct packed {
    logic              mode;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  output_limit;
    logic [LIM_W-1:0]  integral_limit;
  } pidpd_cfg_t;

  // lim is never negative
  function automatic logic signed [ACC_W-1:0] clamp_sym(
    input logic signed [ACC_W-1:0] v,
    input logic signed [ACC_W-1:0] lim
  );
    logic signed [ACC_W-1:0] res;
    if (v > lim) begin
      res = lim;
    end else if (v < -lim) begin
      res = -lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> src/pidpd_datapath.sv
module pidpd_datapath
  import pidpd_pkg::*;
(
  input  pidpd_cfg_t              cfg,
  input  pidpd_state_t            st,
  input  logic signed [ERR_W-1:0] err,
  output pidpd_state_t            st_nxt,
  output logic signed [DATA_W-1:0] drive
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(8388608);

  logic signed [ERR_W:0]   d1;
  logic signed [ERR_W+1:0] d2;
  logic signed [ERR_W+1:0] p_opnd;
  logic signed [ERR_W+1:0] d_opnd;
  logic signed [GAIN_W:0]  kp_s;
  logic signed [GAIN_W:0]  ki_s;
  logic signed [GAIN_W:0]  kd_s;
  logic signed [ACC_W-1:0] prod_p;
  logic signed [ACC_W-1:0] prod_i;
  logic signed [ACC_W-1:0] prod_d;
  logic signed [ACC_W-1:0] ilim;
  logic signed [ACC_W-1:0] olim;
  logic signed [ACC_W-1:0] isum;
  logic signed [ACC_W-1:0] iclamp;
  logic signed [ACC_W-1:0] isat;
  logic signed [ACC_W-1:0] sum_pos;
  logic signed [ACC_W-1:0] sum_inc;
  logic signed [ACC_W-1:0] out_c;
  logic signed [SUM_W-1:0] os_adj;

  assign d1 = {err[ERR_W-1], err} - {st.err_now[ERR_W-1], st.err_now};
  // second difference: e - 2*e[-1] + e[-2]
  assign d2 = {{2{err[ERR_W-1]}}, err}
            - {st.err_now[ERR_W-1], st.err_now, 1'b0}
            + {{2{st.err_prev[ERR_W-1]}}, st.err_prev};

  assign p_opnd = (cfg.mode == MODE_INCREMENTAL) ? {d1[ERR_W], d1}
                                                 : {{2{err[ERR_W-1]}}, err};
  assign d_opnd = (cfg.mode == MODE_INCREMENTAL) ? d2 : {d1[ERR_W], d1};

  assign kp_s = {1'b0, cfg.gain_p};
  assign ki_s = {1'b0, cfg.gain_i};
  assign kd_s = {1'b0, cfg.gain_d};

  assign prod_p = ACC_W'(kp_s) * ACC_W'(p_opnd);
  assign prod_i = ACC_W'(ki_s) * ACC_W'(err);
  assign prod_d = ACC_W'(kd_s) * ACC_W'(d_opnd);

  assign ilim = {{(ACC_W-LIM_W-FRAC_W){1'b0}}, cfg.integral_limit, {FRAC_W{1'b0}}};
  assign olim = {{(ACC_W-LIM_W-FRAC_W){1'b0}}, cfg.output_limit, {FRAC_W{1'b0}}};

  assign isum    = ACC_W'(st.integral_sum) + prod_i;
  assign iclamp  = clamp_sym(isum, ilim);
  assign sum_pos = prod_p + iclamp + prod_d;

  always_comb begin
    if (prod_i > SAT_MAX) begin
      isat = SAT_MAX;
    end else if (prod_i < SAT_MIN) begin
      isat = SAT_MIN;
    end else begin
      isat = prod_i;
    end
  end

  assign sum_inc = ACC_W'(st.output_sum) + prod_p + prod_i + prod_d;

  assign out_c = clamp_sym((cfg.mode == MODE_INCREMENTAL) ? sum_inc : sum_pos, olim);

  always_comb begin
    st_nxt.err_now      = err;
    st_nxt.err_prev     = st.err_now;
    st_nxt.integral_sum = (cfg.mode == MODE_INCREMENTAL) ? isat[SUM_W-1:0]
                                                         : iclamp[SUM_W-1:0];
    st_nxt.output_sum   = out_c[SUM_W-1:0];
  end

  // truncate toward zero: bias negatives before the shift
  assign os_adj = out_c[SUM_W-1] ? (out_c[SUM_W-1:0] + SUM_W'(255))
                                 : out_c[SUM_W-1:0];
  assign drive  = os_adj[SUM_W-1:FRAC_W];

endmodule

>>> src/pid_controller_position_delta.sv
// channel  direction  payload                           handshake
// in_      input      in_measured_value, in_target_value in_valid / in_stall
// out_     output     out_drive_value                   out_valid / out_stall
// cfg_     input      cfg_index, cfg_data               cfg_we
//
// One sample per cycle unless out_stall holds; out_valid rises as a sample leaves err1_r.
// The error is registered on entry; the multiplies, integral clamp and output clamp
// sit combinationally before the result register, which also updates the loop state.
// Synchronous active-low reset clears the error history, the sums and the valid flags.
// A stalled result holds the pipe; the input stage still fills while the output waits.
module pid_controller_position_delta
  import pidpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_measured_value,
  input  logic signed [DATA_W-1:0] in_target_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_drive_value,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  pidpd_cfg_t              cfg_r;
  pidpd_state_t            st_r;
  pidpd_state_t            st_nxt;
  logic                    v1_r;
  logic signed [ERR_W-1:0] err1_r;
  logic                    out_valid_r;
  logic signed [DATA_W-1:0] drive_r;
  logic signed [DATA_W-1:0] drive_nxt;
  logic                    advance;
  logic                    in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = v1_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_POSITIONAL;
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.output_limit   <= '1;
      cfg_r.integral_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   cfg_r.mode           <= cfg_data[0];
        REG_GAIN_P: cfg_r.gain_p         <= cfg_data;
        REG_GAIN_I: cfg_r.gain_i         <= cfg_data;
        REG_GAIN_D: cfg_r.gain_d         <= cfg_data;
        REG_OLIM:   cfg_r.output_limit   <= cfg_data[LIM_W-1:0];
        REG_ILIM:   cfg_r.integral_limit <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (!v1_r || advance) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      err1_r <= {in_target_value[DATA_W-1], in_target_value}
              - {in_measured_value[DATA_W-1], in_measured_value};
    end
  end

  pidpd_datapath u_datapath (
    .cfg    (cfg_r),
    .st     (st_r),
    .err    (err1_r),
    .st_nxt (st_nxt),
    .drive  (drive_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= v1_r;
      if (v1_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v1_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = drive_r;

endmodule
